// ----- rtl/pipeo_pkg.sv -----
// shared types and constants for the even-odd point in polygon block
// no dependencies; imported by every module of the block
package pipeo_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } seg_t;

    // one word of edge work handed from front to back
    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        seg_t                         seg_open;
        seg_t                         seg_close;
        logic                         first;
        logic                         last;
    } work_t;

endpackage

// ----- rtl/pipeo_front.sv -----
// front end: accepts vertex words, keeps first and previous vertex, forms edges
// depends on pipeo_pkg
module pipeo_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] vertex_y,
    input  logic                                   first_vertex,
    input  logic                                   last_vertex,
    output logic                                   enq,
    output pipeo_pkg::work_t                       enq_data,
    input  logic                                   q_full
);
    import pipeo_pkg::*;

    logic signed [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic signed [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    assign full = q_full;
    assign enq  = push && !q_full;

    always_comb
    begin
        first_x_next = first_vertex ? vertex_x : first_x_reg;
        first_y_next = first_vertex ? vertex_y : first_y_reg;

        enq_data.px           = point_x;
        enq_data.py           = point_y;
        enq_data.seg_open.ax  = prev_x_reg;
        enq_data.seg_open.ay  = prev_y_reg;
        enq_data.seg_open.bx  = vertex_x;
        enq_data.seg_open.by  = vertex_y;
        enq_data.seg_close.ax = vertex_x;
        enq_data.seg_close.ay = vertex_y;
        enq_data.seg_close.bx = first_x_next;
        enq_data.seg_close.by = first_y_next;
        enq_data.first        = first_vertex;
        enq_data.last         = last_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else if (enq)
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
        end
    end

endmodule

// ----- rtl/pipeo_queue.sv -----
// short queue of edge work words between front and back
// depends on pipeo_pkg
module pipeo_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enq,
    input  pipeo_pkg::work_t enq_data,
    output logic             full,
    input  logic             deq,
    output pipeo_pkg::work_t deq_data,
    output logic             empty
);
    import pipeo_pkg::*;

    work_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign deq_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !deq)
            cnt_next = cnt_reg + 1'b1;
        else if (deq && !enq)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            mem_reg[wr_ptr_reg] <= enq_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (deq)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !enq || deq)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/pipeo_back.sv -----
// back end: three-stage edge test pipeline, parity and boundary tracking, result queue
// depends on pipeo_pkg
module pipeo_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  pipeo_pkg::work_t q_data,
    output logic             deq,
    output logic             empty,
    input  logic             pop,
    output logic             inside_res,
    output logic             on_boundary
);
    import pipeo_pkg::*;

    typedef struct packed {
        logic box;
        logic strad;
        logic dypos;
    } flag_t;

    typedef struct packed {
        logic in_poly;
        logic bound;
    } res_t;

    seg_t                        segs [2];
    logic signed [DIFF_BITS-1:0] dxe_c [2], dyp_c [2], dye_c [2], dxp_c [2];
    flag_t                       flag_c [2];

    logic                        s1_valid_reg, s1_first_reg, s1_last_reg;
    logic signed [DIFF_BITS-1:0] s1_dxe_reg [2], s1_dyp_reg [2];
    logic signed [DIFF_BITS-1:0] s1_dye_reg [2], s1_dxp_reg [2];
    flag_t                       s1_flag_reg [2];

    logic                        s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_BITS-1:0] s2_m1_reg [2], s2_m2_reg [2];
    flag_t                       s2_flag_reg [2];

    logic                        s3_valid_reg, s3_first_reg, s3_last_reg;
    logic signed [PROD_BITS-1:0] s3_m1_reg [2], s3_m2_reg [2];
    flag_t                       s3_flag_reg [2];

    logic signed [CROSS_BITS-1:0] cr_c [2];
    logic                         en_c [2], on_c [2], cross_c [2];
    logic                         parity_reg, parity_next, parity_acc;
    logic                         bound_reg, bound_next, bound_acc;

    res_t       ofifo_reg [2];
    logic       owr_reg, ord_reg;
    logic [1:0] ocnt_reg;
    logic       ofull, opush, opop, adv;

    assign ofull = (ocnt_reg == 2'd2);
    assign adv   = !(s3_valid_reg && s3_last_reg && ofull);
    assign deq   = adv && !q_empty;
    assign opush = adv && s3_valid_reg && s3_last_reg;
    assign opop  = pop && !empty;
    assign empty = (ocnt_reg == 2'd0);

    assign inside_res  = ofifo_reg[ord_reg].in_poly;
    assign on_boundary = ofifo_reg[ord_reg].bound;

    // stage one: differences and range compares
    always_comb
    begin
        segs[0] = q_data.seg_open;
        segs[1] = q_data.seg_close;
        for (int i = 0; i < 2; i++)
        begin
            dxe_c[i] = DIFF_BITS'(segs[i].bx) - DIFF_BITS'(segs[i].ax);
            dyp_c[i] = DIFF_BITS'(q_data.py) - DIFF_BITS'(segs[i].ay);
            dye_c[i] = DIFF_BITS'(segs[i].by) - DIFF_BITS'(segs[i].ay);
            dxp_c[i] = DIFF_BITS'(q_data.px) - DIFF_BITS'(segs[i].ax);
            flag_c[i].box =
                ((segs[i].ax <= q_data.px && q_data.px <= segs[i].bx) ||
                 (segs[i].bx <= q_data.px && q_data.px <= segs[i].ax)) &&
                ((segs[i].ay <= q_data.py && q_data.py <= segs[i].by) ||
                 (segs[i].by <= q_data.py && q_data.py <= segs[i].ay));
            flag_c[i].strad = (segs[i].ay > q_data.py) != (segs[i].by > q_data.py);
            flag_c[i].dypos = segs[i].by > segs[i].ay;
        end
    end

    // stage three: cross product sign and accumulation
    always_comb
    begin
        en_c[0] = !s3_first_reg;
        en_c[1] = s3_last_reg;
        for (int i = 0; i < 2; i++)
        begin
            cr_c[i]    = CROSS_BITS'(s3_m1_reg[i]) - CROSS_BITS'(s3_m2_reg[i]);
            on_c[i]    = en_c[i] && (cr_c[i] == '0) && s3_flag_reg[i].box;
            cross_c[i] = en_c[i] && s3_flag_reg[i].strad &&
                         (s3_flag_reg[i].dypos ? (cr_c[i] < 0) : (cr_c[i] > 0));
        end
        parity_acc  = (s3_first_reg ? 1'b0 : parity_reg) ^ cross_c[0] ^ cross_c[1];
        bound_acc   = (s3_first_reg ? 1'b0 : bound_reg) | on_c[0] | on_c[1];
        parity_next = parity_reg;
        bound_next  = bound_reg;
        if (adv && s3_valid_reg)
        begin
            parity_next = s3_last_reg ? 1'b0 : parity_acc;
            bound_next  = s3_last_reg ? 1'b0 : bound_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s1_dxe_reg[i]  <= dxe_c[i];
                s1_dyp_reg[i]  <= dyp_c[i];
                s1_dye_reg[i]  <= dye_c[i];
                s1_dxp_reg[i]  <= dxp_c[i];
                s1_flag_reg[i] <= flag_c[i];
                s2_m1_reg[i]   <= s1_dxe_reg[i] * s1_dyp_reg[i];
                s2_m2_reg[i]   <= s1_dye_reg[i] * s1_dxp_reg[i];
                s2_flag_reg[i] <= s1_flag_reg[i];
                s3_m1_reg[i]   <= s2_m1_reg[i];
                s3_m2_reg[i]   <= s2_m2_reg[i];
                s3_flag_reg[i] <= s2_flag_reg[i];
            end
            s1_first_reg <= q_data.first;
            s1_last_reg  <= q_data.last;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
        end
        if (opush)
            ofifo_reg[owr_reg] <= '{in_poly: parity_acc | bound_acc, bound: bound_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
            bound_reg    <= 1'b0;
            owr_reg      <= 1'b0;
            ord_reg      <= 1'b0;
            ocnt_reg     <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= !q_empty;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            parity_reg <= parity_next;
            bound_reg  <= bound_next;
            if (opush)
                owr_reg <= !owr_reg;
            if (opop)
                ord_reg <= !ord_reg;
            if (opush && !opop)
                ocnt_reg <= ocnt_reg + 2'd1;
            else if (opop && !opush)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        opush |=> !parity_reg && !bound_reg)
        else $error("accumulators not cleared after result");

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        opush |-> !ofull || opop)
        else $error("result queue written while full");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> s3_valid_reg && s3_last_reg)
        else $error("stalled result word lost");

endmodule

// ----- rtl/point_in_polygon_even_odd.sv -----
// even-odd point in polygon test over a vertex stream, top level
// a result passes through the work queue, the edge test stages and the result queue
// throughput: one vertex word per cycle while full is low (three-stage edge pipeline)
// a four-word queue separates front and back; a two-word result queue feeds the output
// reset clears stored vertices, accumulators and all queues; no clearing pass
// depends on pipeo_pkg, pipeo_front, pipeo_queue, pipeo_back
module point_in_polygon_even_odd (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [pipeo_pkg::COORD_BITS-1:0] vertex_y,
    input  logic                                   first_vertex,
    input  logic                                   last_vertex,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   inside_res,
    output logic                                   on_boundary
);
    import pipeo_pkg::*;

    logic  enq, q_full, deq, q_empty;
    work_t enq_data, deq_data;

    pipeo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .point_x      (point_x),
        .point_y      (point_y),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .enq          (enq),
        .enq_data     (enq_data),
        .q_full       (q_full)
    );

    pipeo_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (enq_data),
        .full     (q_full),
        .deq      (deq),
        .deq_data (deq_data),
        .empty    (q_empty)
    );

    pipeo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (deq_data),
        .deq         (deq),
        .empty       (empty),
        .pop         (pop),
        .inside_res  (inside_res),
        .on_boundary (on_boundary)
    );

endmodule

// ----- test/tb_point_in_polygon_even_odd.sv -----
// self-checking testbench for the even-odd point in polygon block
// drives vertex words through the push/full side and checks results popped on the other side
// depends on pipeo_pkg and point_in_polygon_even_odd
module tb_point_in_polygon_even_odd;

    import pipeo_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        bit in_poly;
        bit boundary;
    } verdict_t;

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    coord_t point_x;
    coord_t point_y;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   first_vertex;
    logic   last_vertex;
    logic   empty;
    logic   pop;
    logic   inside_res;
    logic   on_boundary;

    point_in_polygon_even_odd dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .point_x      (point_x),
        .point_y      (point_y),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .empty        (empty),
        .pop          (pop),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary)
    );

    // predictor state
    coord_t poly_first_x;
    coord_t poly_first_y;
    coord_t poly_prev_x;
    coord_t poly_prev_y;
    bit     ray_parity;
    bit     edge_hit;

    verdict_t pending_verdicts[$];
    verdict_t got_want;
    int       mismatches;
    int       send_idle_pct;
    int       pop_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("point_in_polygon_even_odd regression: fail");
        $finish;
    end

    function automatic void test_edge(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
        longint cr;
        longint dy;
        longint num;
        bit     left;
        cr = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        if (cr == 0 && ((ax < bx) ? ax : bx) <= px && px <= ((ax > bx) ? ax : bx) &&
            ((ay < by) ? ay : by) <= py && py <= ((ay > by) ? ay : by))
            edge_hit = 1'b1;
        if ((ay > py) != (by > py))
        begin
            dy = by - ay;
            num = (ax - px) * dy + (py - ay) * (bx - ax);
            left = (dy > 0) ? (num < 0) : (num > 0);
            if (left)
                ray_parity = ~ray_parity;
        end
    endfunction

    function automatic void track_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                                         bit is_first, bit is_last);
        verdict_t v;
        if (is_first)
        begin
            poly_first_x = vx;
            poly_first_y = vy;
            ray_parity = 1'b0;
            edge_hit = 1'b0;
        end
        else
            test_edge(poly_prev_x, poly_prev_y, vx, vy, px, py);
        poly_prev_x = vx;
        poly_prev_y = vy;
        if (is_last)
        begin
            test_edge(vx, vy, poly_first_x, poly_first_y, px, py);
            v.in_poly = edge_hit | ray_parity;
            v.boundary = edge_hit;
            pending_verdicts.push_back(v);
            ray_parity = 1'b0;
            edge_hit = 1'b0;
        end
    endfunction

    // one vertex word; returns right after the edge that accepts it, push left high
    task automatic send_word(coord_t px, coord_t py, coord_t vx, coord_t vy,
                             bit is_first, bit is_last);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        point_x      <= px;
        point_y      <= py;
        vertex_x     <= vx;
        vertex_y     <= vy;
        first_vertex <= is_first;
        last_vertex  <= is_last;
        push         <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        track_vertex(px, py, vx, vy, is_first, is_last);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // result checker
    initial
    begin
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word: inside_res=%0b on_boundary=%0b",
                                 inside_res, on_boundary);
                    mismatches++;
                end
                else
                begin
                    got_want = pending_verdicts.pop_front();
                    if (inside_res !== got_want.in_poly ||
                        on_boundary !== got_want.boundary)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: inside_res exp %0b got %0b, ",
                                      "on_boundary exp %0b got %0b"},
                                     got_want.in_poly, inside_res,
                                     got_want.boundary, on_boundary);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver side
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // no first flag after reset: stored origin acts as first vertex
    task automatic test_no_first_flag();
        send_word(8, 2, 10, 0, 1'b0, 1'b0);
        send_word(8, 2, 10, 10, 1'b0, 1'b1);
    endtask

    task automatic test_single_vertex();
        send_word(3, -4, 3, -4, 1'b1, 1'b1);
        send_word(3, -3, 3, -4, 1'b1, 1'b1);
    endtask

    task automatic test_extreme_square();
        send_word(0, 0, -32768, -32768, 1'b1, 1'b0);
        send_word(0, 0, 32767, -32768, 1'b0, 1'b0);
        send_word(0, 0, 32767, 32767, 1'b0, 1'b0);
        send_word(0, 0, -32768, 32767, 1'b0, 1'b1);
        send_word(-32768, 32767, -32768, -32768, 1'b1, 1'b0);
        send_word(-32768, 32767, 32767, -32768, 1'b0, 1'b0);
        send_word(-32768, 32767, 32767, 32767, 1'b0, 1'b0);
        send_word(32767, -1, -32768, 32767, 1'b0, 1'b1);
    endtask

    task automatic test_repeated_vertex();
        send_word(2, 2, 0, 0, 1'b1, 1'b0);
        send_word(2, 2, 0, 0, 1'b0, 1'b0);
        send_word(2, 2, 6, 0, 1'b0, 1'b0);
        send_word(2, 2, 0, 6, 1'b0, 1'b1);
    endtask

    // ray through vertices at the height of the point
    task automatic test_vertex_on_ray();
        send_word(8, 0, 0, -4, 1'b1, 1'b0);
        send_word(8, 0, 4, 0, 1'b0, 1'b0);
        send_word(8, 0, 0, 4, 1'b0, 1'b0);
        send_word(8, 0, -4, 0, 1'b0, 1'b1);
        send_word(2, 0, 0, -4, 1'b1, 1'b0);
        send_word(2, 0, 4, 0, 1'b0, 1'b0);
        send_word(2, 0, 0, 4, 1'b0, 1'b0);
        send_word(2, 0, -4, 0, 1'b0, 1'b1);
    endtask

    // no first flag after a result: continues from the kept vertices
    task automatic test_continue_after_result();
        send_word(1, 1, 4, 4, 1'b0, 1'b1);
    endtask

    function automatic coord_t rand_coord(int mode);
        int c;
        case (mode)
            0: c = int'($urandom_range(24)) - 12;
            1: c = int'($urandom_range(1) ? -32768 : 32747) + int'($urandom_range(20));
            default: c = int'($urandom_range(65535)) - 32768;
        endcase
        return coord_t'(c);
    endfunction

    task automatic test_random_polygons(int words);
        int     sent;
        int     n;
        int     i;
        int     j;
        int     mode;
        int     kind;
        bit     drop_first;
        longint sx;
        longint sy;
        coord_t vxs[8];
        coord_t vys[8];
        coord_t qx;
        coord_t qy;
        sent = 0;
        while (sent < words)
        begin
            mode = $urandom_range(2);
            if ($urandom_range(99) < 10)
            begin
                send_word(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                          rand_coord(mode), 1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                n = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : $urandom_range(3, 8);
                for (i = 0; i < n; i++)
                begin
                    vxs[i] = rand_coord(mode);
                    vys[i] = rand_coord(mode);
                end
                kind = $urandom_range(3);
                i = $urandom_range(n - 1);
                j = (i + 1) % n;
                case (kind)
                    0:
                    begin
                        qx = vxs[i];
                        qy = vys[i];
                    end
                    1:
                    begin
                        sx = longint'(vxs[i]) + longint'(vxs[j]);
                        sy = longint'(vys[i]) + longint'(vys[j]);
                        if (sx % 2 == 0 && sy % 2 == 0)
                        begin
                            qx = coord_t'(sx / 2);
                            qy = coord_t'(sy / 2);
                        end
                        else
                        begin
                            qx = vxs[j];
                            qy = vys[j];
                        end
                    end
                    2:
                    begin
                        qx = rand_coord(mode);
                        qy = vys[i];
                    end
                    default:
                    begin
                        qx = rand_coord(mode);
                        qy = rand_coord(mode);
                    end
                endcase
                drop_first = ($urandom_range(99) < 5);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(99) < 8)
                        send_word(rand_coord(mode), rand_coord(mode), vxs[i], vys[i],
                                  (i == 0) && !drop_first, i == n - 1);
                    else
                        send_word(qx, qy, vxs[i], vys[i], (i == 0) && !drop_first, i == n - 1);
                end
                sent += n;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        point_x       = '0;
        point_y       = '0;
        vertex_x      = '0;
        vertex_y      = '0;
        first_vertex  = 1'b0;
        last_vertex   = 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        ray_parity    = 1'b0;
        edge_hit      = 1'b0;
        poly_first_x  = '0;
        poly_first_y  = '0;
        poly_prev_x   = '0;
        poly_prev_y   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_first_flag();
        test_single_vertex();
        test_extreme_square();
        test_repeated_vertex();
        test_vertex_on_ray();
        test_continue_after_result();
        test_random_polygons(125);
        wait_for_results();

        send_idle_pct = 59;
        pop_stall_pct = 0;
        test_random_polygons(125);
        wait_for_results();

        send_idle_pct = 0;
        pop_stall_pct = 59;
        test_random_polygons(125);
        wait_for_results();

        send_idle_pct = 32;
        pop_stall_pct = 32;
        test_random_polygons(125);
        wait_for_results();

        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("point_in_polygon_even_odd regression: pass");
        else
            $display("point_in_polygon_even_odd regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pipeo_pkg.sv
rtl/pipeo_front.sv
rtl/pipeo_queue.sv
rtl/pipeo_back.sv
rtl/point_in_polygon_even_odd.sv
test/tb_point_in_polygon_even_odd.sv
